// File: rtl/dct_pkg.sv
// Package for the detection confirmation table.
// Table geometry, field widths, register indexes, status codes and controller states.
// Every other file in rtl imports it.
package dct_pkg;
	localparam int TableDepth = 64;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);
	localparam int PosW = 24;
	localparam int IdW = 16;
	localparam int StampW = 32;
	localparam int HitsW = 9;
	localparam int SqW = 35;
	localparam int InW = IdW + 3 * PosW + StampW;
	localparam int InBytesW = ((InW + 7) / 8) * 8;
	localparam int OutW = 2 + 6 + HitsW + 7 + 7 + 7;
	localparam int OutBytesW = ((OutW + 7) / 8) * 8;
	localparam int CfgIdxW = 2;
	localparam logic [HitsW-1:0] HitsMax = '1;

	typedef enum logic [CfgIdxW-1:0] {
		REG_COUNT_LIMIT = 2'd0,
		REG_AGE_LIMIT   = 2'd1,
		REG_DIST_LIMIT  = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_MATCHED  = 2'd0,
		ST_INSERTED = 2'd1,
		ST_DROPPED  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PURGE,
		S_PURGE_WAIT,
		S_MATCH,
		S_MATCH_WAIT,
		S_FINISH,
		S_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic purge_rd;
		logic match_init;
		logic match_rd;
		logic finish;
	} dct_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic found;
	} dct_sts_t;
endpackage

// File: rtl/dct_ctrl.sv
// Controller state machine of the detection confirmation table.
// Sequences purge, match and update; depends on dct_pkg.
module dct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              out_fire,
	input  dct_pkg::dct_sts_t sts,
	output dct_pkg::dct_cmd_t cmd,
	output logic              busy,
	output logic              out_valid
);
	import dct_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (in_fire) begin
					cmd.start = 1'b1;
					state_d = S_PURGE;
				end
			end
			S_PURGE: begin
				if (sts.scan_done) begin
					cmd.match_init = 1'b1;
					state_d = S_MATCH;
				end else begin
					cmd.purge_rd = 1'b1;
					state_d = S_PURGE_WAIT;
				end
			end
			S_PURGE_WAIT: state_d = S_PURGE;
			S_MATCH: begin
				if (sts.scan_done || sts.found) state_d = S_FINISH;
				else begin
					cmd.match_rd = 1'b1;
					state_d = S_MATCH_WAIT;
				end
			end
			S_MATCH_WAIT: state_d = S_MATCH;
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_fire) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) cmd.start |=> state_q == S_PURGE)
		else $error("start did not enter purge");
	assert property (@(posedge clk) disable iff (!arst_n) out_valid && !out_fire |=> out_valid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n) $countones(cmd) <= 1)
		else $error("several commands at once");
endmodule

// File: rtl/dct_datapath.sv
// Datapath of the detection confirmation table: entry memory, purge compaction,
// match gate and result register; depends on dct_pkg.
module dct_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dct_pkg::dct_cmd_t             cmd,
	output dct_pkg::dct_sts_t             sts,
	input  logic [dct_pkg::InW-1:0]       item,
	input  logic [7:0]                    count_limit,
	input  logic [dct_pkg::StampW-1:0]    age_limit_ms,
	input  logic [15:0]                   distance_limit_mm,
	output logic [dct_pkg::OutW-1:0]      result
);
	import dct_pkg::*;

	localparam int EntW = IdW + 3 * PosW + StampW + HitsW;

	logic [EntW-1:0] mem [TableDepth];
	logic [EntW-1:0] rd_s1;
	logic [CntW-1:0] occ_q, rd_q, keep_q;
	logic [IdxW-1:0] rd_idx_s1, slot_q;
	logic [6:0] nconf_q, nstale_q;
	logic found_q;
	logic phase_q;
	logic [HitsW-1:0] hits_q;
	logic [SqW-1:0] limsq_q;

	logic [IdW-1:0] in_id;
	logic signed [PosW-1:0] in_x, in_y, in_z;
	logic [StampW-1:0] in_stamp;
	assign {in_stamp, in_z, in_y, in_x, in_id} = item;

	logic [IdW-1:0] e_id;
	logic signed [PosW-1:0] e_x, e_y, e_z;
	logic [StampW-1:0] e_seen;
	logic [HitsW-1:0] e_hits;
	assign {e_hits, e_seen, e_z, e_y, e_x, e_id} = rd_s1;

	logic rd_pend_s1, rd_kind_s1;
	logic is_conf, is_stale;
	assign is_conf = e_hits > {1'b0, count_limit};
	assign is_stale = (in_stamp - e_seen) > age_limit_ms;

	logic signed [PosW:0] dx, dy, dz;
	logic [PosW:0] mx, my, mz;
	logic [31:0] sx, sy, sz;
	logic big;
	assign dx = {in_x[PosW-1], in_x} - {e_x[PosW-1], e_x};
	assign dy = {in_y[PosW-1], in_y} - {e_y[PosW-1], e_y};
	assign dz = {in_z[PosW-1], in_z} - {e_z[PosW-1], e_z};
	assign mx = dx[PosW] ? -dx : dx;
	assign my = dy[PosW] ? -dy : dy;
	assign mz = dz[PosW] ? -dz : dz;
	assign big = (mx[PosW:16] != '0) || (my[PosW:16] != '0) || (mz[PosW:16] != '0);
	assign sx = mx[15:0] * mx[15:0];
	assign sy = my[15:0] * my[15:0];
	assign sz = mz[15:0] * mz[15:0];

	logic hit_now;
	assign hit_now = !big && (e_id == in_id) &&
		(({3'b0, sx} + {3'b0, sy} + {3'b0, sz}) < limsq_q);

	assign sts.scan_done = !rd_pend_s1 && (rd_q >= (phase_q ? keep_q : occ_q));
	assign sts.found = found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.purge_rd || cmd.match_rd;
			if (cmd.finish) begin
				if (!found_q && keep_q < CntW'(TableDepth)) occ_q <= keep_q + 1'b1;
				else occ_q <= keep_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rd_q <= '0;
			keep_q <= '0;
			nconf_q <= '0;
			nstale_q <= '0;
			found_q <= 1'b0;
			phase_q <= 1'b0;
			limsq_q <= SqW'(32'(distance_limit_mm) * 32'(distance_limit_mm));
		end
		if (cmd.match_init) begin
			rd_q <= '0;
			phase_q <= 1'b1;
		end
		if (cmd.purge_rd || cmd.match_rd) begin
			rd_s1 <= mem[rd_q[IdxW-1:0]];
			rd_idx_s1 <= rd_q[IdxW-1:0];
			rd_kind_s1 <= cmd.match_rd;
			rd_q <= rd_q + 1'b1;
		end
		if (rd_pend_s1 && !rd_kind_s1) begin
			if (is_conf) nconf_q <= nconf_q + 1'b1;
			else if (is_stale) nstale_q <= nstale_q + 1'b1;
			else begin
				mem[keep_q[IdxW-1:0]] <= rd_s1;
				keep_q <= keep_q + 1'b1;
			end
		end
		if (rd_pend_s1 && rd_kind_s1 && hit_now) begin
			found_q <= 1'b1;
			slot_q <= rd_idx_s1;
			hits_q <= (e_hits == HitsMax) ? e_hits : e_hits + 1'b1;
			mem[rd_idx_s1] <= {(e_hits == HitsMax) ? e_hits : e_hits + 1'b1,
				e_seen, e_z, e_y, e_x, e_id};
		end
		if (cmd.finish) begin
			if (found_q)
				result <= {7'(keep_q), nstale_q, nconf_q, hits_q, 6'(slot_q), ST_MATCHED};
			else if (keep_q < CntW'(TableDepth)) begin
				mem[keep_q[IdxW-1:0]] <= {HitsW'(0), in_stamp, in_z, in_y, in_x, in_id};
				result <= {7'(keep_q + 1'b1), nstale_q, nconf_q, HitsW'(0), 6'(keep_q),
					ST_INSERTED};
			end else
				result <= {7'(keep_q), nstale_q, nconf_q, HitsW'(0), 6'(0), ST_DROPPED};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) occ_q <= CntW'(TableDepth))
		else $error("occupancy overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 && !rd_kind_s1 |-> keep_q < rd_q)
		else $error("compaction overtook read");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.finish |-> !rd_pend_s1)
		else $error("finish during read");
endmodule

// File: rtl/detection_confirmation_table.sv
// Top level of the detection confirmation table.
// Joins dct_ctrl and dct_datapath, holds the configuration registers; depends on dct_pkg.
// One detection purges and compacts the table, then searches it:
// each entry is read once from the single-port table memory to purge and compact, then
// the kept entries are read one at a time until the first match. The next item is
// taken once the result has been transferred.
module detection_confirmation_table (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// marker_id, pos_x, pos_y, pos_z, stamp_ms
	input  logic [dct_pkg::InBytesW-1:0]     s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// status, slot, hit_count, confirmed_removed, stale_removed, occupancy
	output logic [dct_pkg::OutBytesW-1:0]    m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dct_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [31:0]                      cfg_data
);
	import dct_pkg::*;

	logic [7:0] count_limit_q;
	logic [31:0] age_limit_q;
	logic [15:0] dist_limit_q;
	logic busy, in_fire, out_fire;
	dct_cmd_t cmd;
	dct_sts_t sts;
	logic [OutW-1:0] result;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata = OutBytesW'(result);

	logic [InW-1:0] item_q;
	always_ff @(posedge clk) if (in_fire) item_q <= s_axis_tdata[InW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_limit_q <= 8'd10;
			age_limit_q <= 32'd10000;
			dist_limit_q <= 16'd1000;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_COUNT_LIMIT: count_limit_q <= cfg_data[7:0];
				REG_AGE_LIMIT: age_limit_q <= cfg_data;
				REG_DIST_LIMIT: dist_limit_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	dct_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.sts(sts), .cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid)
	);

	dct_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .item(item_q),
		.count_limit(count_limit_q), .age_limit_ms(age_limit_q),
		.distance_limit_mm(dist_limit_q), .result(result)
	);
endmodule

// File: tb/tb_top.sv
// Testbench for detection_confirmation_table: directed and random detections checked
// against an in-bench model of the candidate table. Depends on dct_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
	import dct_pkg::*;

	typedef struct {
		logic [15:0] id;
		logic signed [23:0] x, y, z;
		logic [31:0] seen;
		logic [8:0] hits;
	} cand_t;

	typedef struct packed {
		logic [6:0] occ;
		logic [6:0] n_stale;
		logic [6:0] n_conf;
		logic [8:0] hits;
		logic [5:0] slot;
		logic [1:0] status;
	} verdict_t;

	localparam int WatchLimit = 3000;
	localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [InBytesW-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [OutBytesW-1:0] m_axis_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	detection_confirmation_table dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	cand_t table_q[$];
	logic [7:0] lim_count = 10;
	logic [31:0] lim_age = 10000;
	logic [15:0] lim_dist = 1000;
	verdict_t verdict_q[$];
	verdict_t exp_v, got_v;
	int n_err = 0, n_items = 0, n_results = 0, n_status[3] = '{0, 0, 0};
	int idle_cnt = 0;
	int out_hold = 0;
	logic [31:0] now_ms = 32'd1000;
	int base_x[12], base_y[12], base_z[12];

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic int noise(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic axis_ok(logic signed [23:0] a, logic signed [23:0] b,
			output logic [33:0] sq);
		longint d;
		d = longint'(a) - longint'(b);
		if (d < 0) d = -d;
		sq = 34'(d * d);
		return d < 65536;
	endfunction

	function automatic verdict_t table_step(logic [15:0] id, logic signed [23:0] x,
			logic signed [23:0] y, logic signed [23:0] z, logic [31:0] stamp);
		verdict_t v;
		cand_t kept[$];
		cand_t c;
		logic [33:0] sx, sy, sz;
		logic [35:0] lim_sq;
		logic okx, oky, okz;
		bit found;
		v = '0;
		found = 0;
		lim_sq = 36'(lim_dist) * 36'(lim_dist);
		foreach (table_q[i]) begin
			if (table_q[i].hits > {1'b0, lim_count}) v.n_conf++;
			else if ((stamp - table_q[i].seen) > lim_age) v.n_stale++;
			else kept.push_back(table_q[i]);
		end
		table_q = kept;
		foreach (table_q[i]) begin
			if (!found && table_q[i].id == id) begin
				okx = axis_ok(x, table_q[i].x, sx);
				oky = axis_ok(y, table_q[i].y, sy);
				okz = axis_ok(z, table_q[i].z, sz);
				if (okx && oky && okz && (36'(sx) + 36'(sy) + 36'(sz) < lim_sq)) begin
					if (table_q[i].hits != 9'h1FF) table_q[i].hits++;
					found = 1;
					v.status = ST_MATCHED;
					v.slot = 6'(i);
					v.hits = table_q[i].hits;
				end
			end
		end
		if (!found) begin
			if (table_q.size() < TableDepth) begin
				c.id = id;
				c.x = x;
				c.y = y;
				c.z = z;
				c.seen = stamp;
				c.hits = '0;
				table_q.push_back(c);
				v.status = ST_INSERTED;
				v.slot = 6'(table_q.size() - 1);
			end else
				v.status = ST_DROPPED;
		end
		v.occ = 7'(table_q.size());
		return v;
	endfunction

	task automatic report(input string what, input verdict_t e, input verdict_t g);
		n_err++;
		if (n_err <= 10)
			$display("mismatch %s: expected st %0d slot %0d hits %0d conf %0d stale %0d occ %0d, got st %0d slot %0d hits %0d conf %0d stale %0d occ %0d",
				what, e.status, e.slot, e.hits, e.n_conf, e.n_stale, e.occ,
				g.status, g.slot, g.hits, g.n_conf, g.n_stale, g.occ);
	endtask

	task automatic send_item(input logic [15:0] id, input logic signed [23:0] x,
			input logic signed [23:0] y, input logic signed [23:0] z, input logic [31:0] stamp);
		verdict_t v;
		repeat (1 + gap_len()) @(posedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {stamp, z, y, x, id};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		s_axis_tvalid <= 1'b0;
		v = table_step(id, x, y, z, stamp);
		verdict_q.push_back(v);
		n_status[v.status]++;
		n_items++;
	endtask

	task automatic drain();
		while (verdict_q.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_COUNT_LIMIT: lim_count = val[7:0];
			REG_AGE_LIMIT: lim_age = val;
			REG_DIST_LIMIT: lim_dist = val[15:0];
			default: ;
		endcase
	endtask

	task automatic clear_table();
		cfg_write(REG_AGE_LIMIT, 32'd0);
		now_ms = now_ms + 32'd1;
		send_item(16'd999, '0, '0, '0, now_ms);
		cfg_write(REG_AGE_LIMIT, 32'd10000);
	endtask

	task automatic test_basic();
		send_item(16'd5, 24'sd0, 24'sd0, 24'sd0, now_ms);
		now_ms = now_ms + 32'd1;
		send_item(16'd5, 24'sd10, -24'sd20, 24'sd30, now_ms);
		send_item(16'd5, 24'sd2000, 24'sd0, 24'sd0, now_ms);
		send_item(16'd7, 24'sd0, 24'sd0, 24'sd0, now_ms);
		for (int k = 0; k < 16; k++) begin
			now_ms = now_ms + 32'($urandom_range(0, 5));
			send_item(16'($urandom_range(0, 3)), 24'(noise(800)), 24'(noise(800)),
				24'(noise(800)), now_ms);
		end
	endtask

	task automatic test_confirm();
		cfg_write(REG_COUNT_LIMIT, 32'd3);
		for (int k = 0; k < 8; k++) begin
			now_ms = now_ms + 32'd1;
			send_item(16'd100, 24'sd500, 24'sd500, 24'sd500, now_ms);
		end
		cfg_write(REG_COUNT_LIMIT, 32'hABCD_EF0A);
	endtask

	task automatic test_stale();
		cfg_write(REG_AGE_LIMIT, 32'd50);
		now_ms = now_ms + 32'd100;
		for (int k = 0; k < 16; k++) begin
			now_ms = now_ms + 32'd20;
			send_item(16'($urandom_range(0, 2)), 24'(noise(300)), 24'(noise(300)),
				24'(noise(300)), now_ms);
		end
		now_ms = 32'hFFFF_FFF0;
		send_item(16'd1, 24'sd0, 24'sd0, 24'sd0, now_ms);
		send_item(16'd2, 24'sd0, 24'sd0, 24'sd0, now_ms);
		now_ms = 32'h0000_0010;
		send_item(16'd1, 24'sd5, 24'sd0, 24'sd0, now_ms);
		now_ms = 32'h0000_0030;
		send_item(16'd2, 24'sd5, 24'sd0, 24'sd0, now_ms);
		cfg_write(REG_AGE_LIMIT, 32'd0);
		send_item(16'd3, 24'sd0, 24'sd0, 24'sd0, now_ms);
		send_item(16'd3, 24'sd0, 24'sd0, 24'sd0, now_ms);
		now_ms = now_ms + 32'd1;
		send_item(16'd3, 24'sd0, 24'sd0, 24'sd0, now_ms);
		cfg_write(REG_AGE_LIMIT, 32'd10000);
	endtask

	task automatic test_full();
		cfg_write(REG_COUNT_LIMIT, 32'd255);
		cfg_write(REG_AGE_LIMIT, 32'hFFFF_FFFF);
		for (int k = 0; k < 70; k++)
			send_item(16'(1000 + k), 24'(k * 5000), 24'sd0, 24'sd0, now_ms);
		for (int k = 0; k < 5; k++)
			send_item(16'(1000 + k), 24'(k * 5000), 24'sd0, 24'sd0, now_ms);
		cfg_write(REG_COUNT_LIMIT, 32'd10);
		clear_table();
	endtask

	task automatic test_distance();
		cfg_write(REG_DIST_LIMIT, 32'd0);
		for (int k = 0; k < 5; k++)
			send_item(16'd200, 24'sd0, 24'sd0, 24'sd0, now_ms);
		clear_table();
		cfg_write(REG_DIST_LIMIT, 32'd100);
		send_item(16'd200, 24'sd0, 24'sd0, 24'sd0, now_ms);
		send_item(16'd200, 24'sd100, 24'sd0, 24'sd0, now_ms);
		send_item(16'd200, 24'sd0, 24'sd99, 24'sd0, now_ms);
		send_item(16'd200, -24'sd70, -24'sd70, 24'sd0, now_ms);
		cfg_write(REG_DIST_LIMIT, 32'hFFFF_FFFF);
		send_item(16'd300, 24'h800000, 24'sd0, 24'sd0, now_ms);
		send_item(16'd300, 24'h810000, 24'sd0, 24'sd0, now_ms);
		send_item(16'd300, 24'h80FFFF, 24'sd0, 24'sd0, now_ms);
		send_item(16'd300, 24'h809C40, 24'sd30000, 24'sd0, now_ms);
		send_item(16'd301, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, now_ms);
		send_item(16'd301, 24'h800000, 24'h800000, 24'h800000, now_ms);
		cfg_write(RegUnused, 32'h0000_1234);
		cfg_write(REG_DIST_LIMIT, 32'd1000);
		clear_table();
	endtask

	task automatic test_random();
		int r;
		int id;
		for (int k = 0; k < 12; k++) begin
			base_x[k] = noise(8000000);
			base_y[k] = noise(8000000);
			base_z[k] = noise(8000000);
		end
		for (int b = 0; b < 15; b++) begin
			cfg_write(REG_COUNT_LIMIT, 32'($urandom_range(0, 15)));
			r = $urandom_range(0, 2);
			if (r == 0) cfg_write(REG_AGE_LIMIT, 32'($urandom_range(20, 400)));
			else if (r == 1) cfg_write(REG_AGE_LIMIT, 32'hFFFF_FFFF);
			else cfg_write(REG_AGE_LIMIT, 32'd10000);
			r = $urandom_range(0, 9);
			if (r == 0) cfg_write(REG_DIST_LIMIT, 32'd0);
			else if (r == 1) cfg_write(REG_DIST_LIMIT, 32'd65535);
			else cfg_write(REG_DIST_LIMIT, 32'($urandom_range(50, 3000)));
			for (int k = 0; k < 104; k++) begin
				id = $urandom_range(0, 11);
				if ($urandom_range(0, 49) == 0)
					now_ms = now_ms + 32'($urandom_range(1000, 100000));
				else
					now_ms = now_ms + 32'($urandom_range(0, 30));
				if ($urandom_range(0, 19) == 0)
					send_item(16'(id), 24'($urandom), 24'($urandom), 24'($urandom), now_ms);
				else
					send_item(16'(id), 24'(base_x[id] + noise(1500)),
						24'(base_y[id] + noise(1500)), 24'(base_z[id] + noise(1500)), now_ms);
			end
			drain();
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) m_axis_tready <= 1'b0;
		else if (out_hold > 0) begin
			m_axis_tready <= 1'b0;
			out_hold <= out_hold - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (m_axis_tvalid && m_axis_tready) out_hold <= gap_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			got_v = m_axis_tdata[OutW-1:0];
			if (verdict_q.size() == 0) report("unexpected result", '0, got_v);
			else begin
				exp_v = verdict_q.pop_front();
				if (got_v !== exp_v) report("result", exp_v, got_v);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WatchLimit) begin
			$display("watchdog: no transfer for %0d cycles", idle_cnt);
			$display("FAIL detection_confirmation_table");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic();
		test_confirm();
		test_stale();
		test_full();
		test_distance();
		test_random();
		drain();
		$display("covered %0d detections: %0d matched, %0d inserted, %0d dropped",
			n_items, n_status[0], n_status[1], n_status[2]);
		$display("confirm and stale purges, stamp wrap, full table, gate edges, config masks");
		if (n_err == 0 && n_results == n_items)
			$display("PASS detection_confirmation_table");
		else begin
			$display("%0d mismatches, %0d results for %0d items", n_err, n_results, n_items);
			$display("FAIL detection_confirmation_table");
		end
		$finish;
	end
endmodule
